[rtl/tcr_pkg.sv]
// Shared types and constants of the triggered capture recorder.
`default_nettype none

package tcr_pkg;

  // Fixed field widths
  localparam int unsigned REQ_BITS   = 2;
  localparam int unsigned CH_BITS    = 3;
  localparam int unsigned IDX_BITS   = 16;
  localparam int unsigned OUT_BITS   = 16;
  localparam int unsigned LEVEL_BITS = 16;
  localparam int unsigned TIMER_BITS = 20;
  localparam int unsigned WIN_BITS   = 17;
  localparam int unsigned CFG_BITS   = 20;
  localparam int unsigned CFG_IDX_BITS = 2;

  // Request codes
  localparam logic [REQ_BITS-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_RETRIG  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLDOFF = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW  = 2'd3;

  // Register reset values
  localparam logic                  RETRIG_RST  = 1'b1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_RST   = 16'd2048;
  localparam logic [TIMER_BITS-1:0] HOLDOFF_RST = 20'd24240;
  localparam logic [WIN_BITS-1:0]   WINDOW_RST  = 17'd48000;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = 20'hFFFFF;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_TICK,
    ST_CMP_S,
    ST_CMP_P,
    ST_CMP_H,
    ST_STORE,
    ST_WRAP,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_CLEAR,
    KIND_READ,
    KIND_SAMPLE
  } kind_t;

  typedef enum logic {
    ALU_INC,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [2:0] {
    OPS_TIMER,
    OPS_SAMPLE,
    OPS_PREV,
    OPS_HOLD,
    OPS_POS,
    OPS_WRAP
  } opsel_t;

  typedef struct packed {
    kind_t kind;
    logic  sweep_last;
    logic  trig_now;
  } sts_t;

  typedef struct packed {
    logic    accept;
    logic    sweep;
    alu_op_t alu_op;
    opsel_t  opsel;
    logic    ld_tick;
    logic    ld_gt;
    logic    ld_le;
    logic    ld_hold;
    logic    store;
    logic    wrap;
    logic    rd_cap;
    logic    commit;
  } ctl_t;

endpackage

`default_nettype wire

[rtl/triggered_capture_recorder_unit.sv]
// Top level of the triggered capture recorder: config, channel state, datapath.
`default_nettype none

// Each channel owns a capture window of DEPTH words, a write position, the last
// sample seen and a saturating tick timer. An item is taken when start is high
// and busy is low; its result word appears for exactly one cycle with out_valid
// high, in the cycle busy drops, and cannot be held off. Every item makes one
// result word. The work runs through one shared adder under a sequencer, one
// step per cycle: a stored sample takes the tick, three compares, the store,
// the wrap and the result step; a sample that restarts capture ends after the
// compares; an in-range read takes the RAM address and the registered read;
// an item with no effect goes straight to the result step. Clear-all, and a
// disconnected sample on a channel whose last sample was nonzero, sweep the
// capture RAM one address per cycle; clear-all sweeps all channel RAMs at once.
// After reset the block runs the same sweep over all channels with busy high
// before it takes the first item. Configuration writes are taken at any time
// on cfg_we; write them only while the block is idle. A window length of 0
// acts as 1 and one above DEPTH acts as DEPTH.

module triggered_capture_recorder_unit #(
  parameter int DEPTH       = 65536,
  parameter int CHANNELS    = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [tcr_pkg::REQ_BITS-1:0]        in_req_type,
  input  wire logic [tcr_pkg::CH_BITS-1:0]         in_channel,
  input  wire logic                                in_connected,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  wire logic [tcr_pkg::IDX_BITS-1:0]        in_read_index,
  output logic                                     out_valid,
  output logic signed [tcr_pkg::OUT_BITS-1:0]      out_through,
  output logic signed [tcr_pkg::OUT_BITS-1:0]      out_read_data,
  output logic [tcr_pkg::OUT_BITS-1:0]             out_write_position,
  output logic                                     out_triggered,
  input  wire logic                                cfg_we,
  input  wire logic [tcr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [tcr_pkg::CFG_BITS-1:0]        cfg_wdata
);

  import tcr_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WW  = 21;  // effective window, up to DEPTH
  localparam int UW  = ((SAMPLE_BITS > WW) ? SAMPLE_BITS : WW) + 1;
  localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);
  localparam logic [WW-1:0] WIN_RST =
    (DEPTH < int'(WINDOW_RST)) ? DEPTH_W : WW'(WINDOW_RST);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Configuration registers
  logic                  en_r;
  logic [LEVEL_BITS-1:0] lvl_r;
  logic [TIMER_BITS-1:0] hold_r;
  logic [WW-1:0]         win_r;
  logic [WW-1:0]         win_cand;
  logic [WW-1:0]         win_nxt;

  // Per-channel state
  logic [AW-1:0]          wpos_r [CHANNELS];
  logic [SAMPLE_BITS-1:0] prev_a_r [CHANNELS];
  logic [TIMER_BITS-1:0]  tmr_a_r [CHANNELS];

  // Working registers for the item in flight
  logic [REQ_BITS-1:0]    req_r;
  logic [CHW-1:0]         ch_r;
  logic                   conn_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [IDX_BITS-1:0]    ridx_r;
  logic                   thr_r;
  logic                   commit_ch_r;
  logic [AW-1:0]          pos_r;
  logic [AW:0]            posinc_r;
  logic [SAMPLE_BITS-1:0] prev_r;
  logic [TIMER_BITS-1:0]  tmr_r;
  logic                   gt_r;
  logic                   le_r;
  logic                   trig_r;
  logic [SAMPLE_BITS-1:0] rd_r;

  // Clearing sweep
  logic [CHANNELS-1:0] clr_mask_r;
  logic [CHANNELS-1:0] clr_mask_nxt;
  logic [AW-1:0]       clr_addr_r;

  // Result word
  logic                out_valid_r;
  logic [OUT_BITS-1:0] through_r;
  logic [OUT_BITS-1:0] rdata_out_r;
  logic [OUT_BITS-1:0] wpos_out_r;
  logic                trig_out_r;

  // Decode of the offered word
  logic                   ch_ok;
  logic                   rd_ok;
  logic                   acc_ch;
  logic [CHW-1:0]         in_ch;
  logic [AW-1:0]          cur_pos;
  logic [SAMPLE_BITS-1:0] cur_prev;
  logic [TIMER_BITS-1:0]  cur_tmr;
  kind_t                  kind;

  // Shared unit
  logic [UW-1:0] alu_a;
  logic [UW-1:0] alu_b;
  logic [UW-1:0] alu_res;
  logic          alu_neg;

  // RAM side
  logic [CHANNELS-1:0]    ram_we;
  logic [AW-1:0]          ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata [CHANNELS];

  sts_t sts;
  ctl_t ctl;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  tcr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  always_comb begin
    sts.kind       = kind;
    sts.sweep_last = (clr_addr_r == LAST_ADDR);
    // Restart when enabled, edge seen and the timer has reached the holdoff
    sts.trig_now   = en_r & gt_r & le_r & ~alu_neg;
  end

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  // Clamp the window length once, at write time
  always_comb begin
    win_cand = WW'(cfg_wdata[WIN_BITS-1:0]);
    if (win_cand == '0) begin
      win_nxt = WW'(1);
    end else if (win_cand > DEPTH_W) begin
      win_nxt = DEPTH_W;
    end else begin
      win_nxt = win_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= RETRIG_RST;
      lvl_r  <= LEVEL_RST;
      hold_r <= HOLDOFF_RST;
      win_r  <= WIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RETRIG:  en_r   <= cfg_wdata[0];
        CFG_LEVEL:   lvl_r  <= cfg_wdata[LEVEL_BITS-1:0];
        CFG_HOLDOFF: hold_r <= cfg_wdata[TIMER_BITS-1:0];
        CFG_WINDOW:  win_r  <= win_nxt;
        default:     en_r   <= en_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Decode the offered word
  // ---------------------------------------------------------------------------
  always_comb begin
    ch_ok    = (5'(in_channel) < 5'(CHANNELS));
    rd_ok    = (WW'(in_read_index) < DEPTH_W);
    in_ch    = CHW'(in_channel);
    cur_pos  = wpos_r[in_ch];
    cur_prev = prev_a_r[in_ch];
    cur_tmr  = tmr_a_r[in_ch];
    acc_ch   = ch_ok && (in_req_type == REQ_SAMPLE || in_req_type == REQ_READ);

    if (in_req_type == REQ_CLEAR) begin
      kind = KIND_CLEAR;
    end else if (!acc_ch) begin
      kind = KIND_NOP;
    end else if (in_req_type == REQ_READ) begin
      kind = rd_ok ? KIND_READ : KIND_NOP;
    end else if (in_connected) begin
      kind = KIND_SAMPLE;
    end else if (cur_prev != '0) begin
      // Source dropped after a nonzero sample: wipe the channel
      kind = KIND_CLEAR;
    end else begin
      kind = KIND_NOP;
    end

    for (int c = 0; c < CHANNELS; c++) begin
      clr_mask_nxt[c] = (in_req_type == REQ_CLEAR) || (CHW'(c) == in_ch);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared unit and its operands
  // ---------------------------------------------------------------------------
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (ctl.opsel)
      OPS_TIMER: alu_a = UW'(tmr_r);
      OPS_SAMPLE: begin
        alu_a = {{(UW-LEVEL_BITS){lvl_r[LEVEL_BITS-1]}}, lvl_r};
        alu_b = {{(UW-SAMPLE_BITS){smp_r[SAMPLE_BITS-1]}}, smp_r};
      end
      OPS_PREV: begin
        alu_a = {{(UW-LEVEL_BITS){lvl_r[LEVEL_BITS-1]}}, lvl_r};
        alu_b = {{(UW-SAMPLE_BITS){prev_r[SAMPLE_BITS-1]}}, prev_r};
      end
      OPS_HOLD: begin
        alu_a = UW'(tmr_r);
        alu_b = UW'(hold_r);
      end
      OPS_POS: alu_a = UW'(pos_r);
      OPS_WRAP: begin
        alu_a = UW'(posinc_r);
        alu_b = UW'(win_r);
      end
      default: alu_a = '0;
    endcase
  end

  tcr_alu #(.WIDTH(UW)) u_alu (
    .op  (ctl.alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .neg (alu_neg)
  );

  // ---------------------------------------------------------------------------
  // Capture RAMs, one per channel; clear-all sweeps them together
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      ram_we[c] = (ctl.sweep && clr_mask_r[c]) || (ctl.store && (ch_r == CHW'(c)));
    end
    ram_wdata = ctl.sweep ? '0 : smp_r;
    if (ctl.sweep) begin
      ram_addr = clr_addr_r;
    end else if (ctl.store) begin
      ram_addr = pos_r;
    end else begin
      ram_addr = AW'(ridx_r);
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ram
    tcr_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[c]),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata[c])
    );
  end

  // ---------------------------------------------------------------------------
  // Control state: channel state, sweep, strobe
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wpos_r[c]   <= '0;
        prev_a_r[c] <= '0;
        tmr_a_r[c]  <= '0;
      end
      clr_mask_r  <= '1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.commit;

      if (ctl.accept) begin
        clr_mask_r <= clr_mask_nxt;
      end

      // Advance the sweep address, wrap to zero after the last entry
      if (ctl.sweep) begin
        clr_addr_r <= (clr_addr_r == LAST_ADDR) ? '0 : clr_addr_r + AW'(1);
      end

      // Write back the channel state at the end of the item
      if (ctl.commit) begin
        if (req_r == REQ_CLEAR) begin
          for (int c = 0; c < CHANNELS; c++) begin
            wpos_r[c]  <= '0;
            tmr_a_r[c] <= '0;
          end
        end else if (commit_ch_r) begin
          wpos_r[ch_r]   <= pos_r;
          tmr_a_r[ch_r]  <= tmr_r;
          prev_a_r[ch_r] <= conn_r ? smp_r : prev_r;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers and result word
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_r       <= in_req_type;
      ch_r        <= in_ch;
      conn_r      <= in_connected;
      smp_r       <= in_sample;
      ridx_r      <= in_read_index;
      thr_r       <= (kind == KIND_SAMPLE);
      commit_ch_r <= (kind == KIND_SAMPLE) ||
                     (kind == KIND_CLEAR && in_req_type != REQ_CLEAR);
      pos_r       <= (acc_ch && kind != KIND_CLEAR) ? cur_pos : '0;
      prev_r      <= (kind == KIND_CLEAR) ? '0 : cur_prev;
      tmr_r       <= (kind == KIND_CLEAR) ? '0 : cur_tmr;
      rd_r        <= '0;
      trig_r      <= 1'b0;
    end

    // Saturating tick
    if (ctl.ld_tick && tmr_r != TIMER_MAX) begin
      tmr_r <= alu_res[TIMER_BITS-1:0];
    end

    if (ctl.ld_gt) begin
      gt_r <= alu_neg;
    end

    if (ctl.ld_le) begin
      le_r <= ~alu_neg;
    end

    // Restart: drop the write, rewind the position and clear the timer
    if (ctl.ld_hold && sts.trig_now) begin
      pos_r  <= '0;
      tmr_r  <= '0;
      trig_r <= 1'b1;
    end

    if (ctl.store) begin
      posinc_r <= alu_res[AW:0];
    end

    // Wrap to zero once position + 1 reaches the window length
    if (ctl.wrap) begin
      pos_r <= alu_neg ? posinc_r[AW-1:0] : '0;
    end

    if (ctl.rd_cap) begin
      rd_r <= ram_rdata[ch_r];
    end

    if (ctl.commit) begin
      through_r   <= thr_r ? OUT_BITS'(smp_r) : '0;
      rdata_out_r <= OUT_BITS'(rd_r);
      wpos_out_r  <= OUT_BITS'(pos_r);
      trig_out_r  <= trig_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_through        = through_r;
  assign out_read_data      = rdata_out_r;
  assign out_write_position = wpos_out_r;
  assign out_triggered      = trig_out_r;

endmodule

`default_nettype wire

[rtl/tcr_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none

module tcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/tcr_alu.sv]
// Shared add/subtract unit: increment or signed difference with sign flag.
`default_nettype none

module tcr_alu #(
  parameter int WIDTH = 22
) (
  input  tcr_pkg::alu_op_t       op,
  input  wire logic [WIDTH-1:0]  a,
  input  wire logic [WIDTH-1:0]  b,
  output logic      [WIDTH-1:0]  res,
  output logic                   neg
);

  import tcr_pkg::*;

  logic [WIDTH:0] a_x;
  logic [WIDTH:0] b_x;
  logic [WIDTH:0] sum;

  // One adder: a + 1 or a + ~b + 1
  always_comb begin
    a_x = {a[WIDTH-1], a};
    b_x = (op == ALU_SUB) ? ~{b[WIDTH-1], b} : '0;
    sum = a_x + b_x + (WIDTH+1)'(1);
    res = sum[WIDTH-1:0];
    neg = sum[WIDTH];
  end

endmodule

`default_nettype wire

[rtl/tcr_ctrl.sv]
// Sequencer that steps one item through the shared unit and the capture RAMs.
`default_nettype none

module tcr_ctrl (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  tcr_pkg::sts_t sts,
  output logic         busy,
  output tcr_pkg::ctl_t ctl
);

  import tcr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          unique case (sts.kind)
            KIND_NOP:    state_nxt = ST_DONE;
            KIND_CLEAR:  state_nxt = ST_SWEEP;
            KIND_READ:   state_nxt = ST_RD_ADDR;
            KIND_SAMPLE: state_nxt = ST_TICK;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sts.sweep_last) state_nxt = ST_DONE;
      end
      ST_TICK:    state_nxt = ST_CMP_S;
      ST_CMP_S:   state_nxt = ST_CMP_P;
      ST_CMP_P:   state_nxt = ST_CMP_H;
      ST_CMP_H:   state_nxt = sts.trig_now ? ST_DONE : ST_STORE;
      ST_STORE:   state_nxt = ST_WRAP;
      ST_WRAP:    state_nxt = ST_DONE;
      ST_RD_ADDR: state_nxt = ST_RD_DATA;
      ST_RD_DATA: state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.alu_op = ALU_INC;
    ctl.opsel  = OPS_TIMER;
    busy       = 1'b1;
    unique case (state_r)
      ST_INIT:  ctl.sweep = 1'b1;
      ST_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      ST_SWEEP: ctl.sweep = 1'b1;
      ST_TICK: begin
        ctl.opsel   = OPS_TIMER;
        ctl.ld_tick = 1'b1;
      end
      ST_CMP_S: begin
        ctl.alu_op = ALU_SUB;
        ctl.opsel  = OPS_SAMPLE;
        ctl.ld_gt  = 1'b1;
      end
      ST_CMP_P: begin
        ctl.alu_op = ALU_SUB;
        ctl.opsel  = OPS_PREV;
        ctl.ld_le  = 1'b1;
      end
      ST_CMP_H: begin
        ctl.alu_op  = ALU_SUB;
        ctl.opsel   = OPS_HOLD;
        ctl.ld_hold = 1'b1;
      end
      ST_STORE: begin
        ctl.opsel = OPS_POS;
        ctl.store = 1'b1;
      end
      ST_WRAP: begin
        ctl.alu_op = ALU_SUB;
        ctl.opsel  = OPS_WRAP;
        ctl.wrap   = 1'b1;
      end
      ST_RD_ADDR: ctl.rd_cap = 1'b0;
      ST_RD_DATA: ctl.rd_cap = 1'b1;
      ST_DONE:    ctl.commit = 1'b1;
      default:    busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

[test/tb_triggered_capture_recorder_unit.sv]
// Self-checking testbench of the triggered capture recorder with its own capture predictor.
`default_nettype none

module tb_triggered_capture_recorder_unit;
  import tcr_pkg::*;

  localparam int NUM_CH      = 6;
  localparam int CAP_DEPTH   = 65536;
  localparam int SMP_BITS    = 16;
  // The package names three request codes; the fourth is the one the block ignores.
  localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
  // Slowest correct run: the power-up sweep, seven channel sweeps, and about
  // 1100 words plus sender gaps; allow several times that before giving up.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    logic [REQ_BITS-1:0]       req;
    logic [CH_BITS-1:0]        ch;
    logic                      conn;
    logic signed [SMP_BITS-1:0] smp;
    logic [IDX_BITS-1:0]       ridx;
  } req_word_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] through;
    logic signed [OUT_BITS-1:0] read_data;
    logic [OUT_BITS-1:0]        wpos;
    logic                       trig;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [REQ_BITS-1:0] in_req_type = REQ_SAMPLE;
  logic [CH_BITS-1:0] in_channel = '0;
  logic in_connected = 1'b0;
  logic signed [SMP_BITS-1:0] in_sample = '0;
  logic [IDX_BITS-1:0] in_read_index = '0;
  logic out_valid;
  logic signed [OUT_BITS-1:0] out_through;
  logic signed [OUT_BITS-1:0] out_read_data;
  logic [OUT_BITS-1:0] out_write_position;
  logic out_triggered;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_RETRIG;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  triggered_capture_recorder_unit #(
    .DEPTH(CAP_DEPTH),
    .CHANNELS(NUM_CH),
    .SAMPLE_BITS(SMP_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_channel(in_channel),
    .in_connected(in_connected),
    .in_sample(in_sample),
    .in_read_index(in_read_index),
    .out_valid(out_valid),
    .out_through(out_through),
    .out_read_data(out_read_data),
    .out_write_position(out_write_position),
    .out_triggered(out_triggered),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predicted recorder state: capture windows, per-channel position, last
  // sample and tick timer, plus the register copy. Starts at the reset values.
  // ---------------------------------------------------------------------------
  bit [SMP_BITS-1:0]          cap_mem [NUM_CH][CAP_DEPTH];
  logic [OUT_BITS-1:0]        wpos [NUM_CH] = '{default: '0};
  logic signed [SMP_BITS-1:0] last_smp [NUM_CH] = '{default: '0};
  logic [TIMER_BITS-1:0]      ticks [NUM_CH] = '{default: '0};
  logic                       retrig_en = RETRIG_RST;
  logic signed [LEVEL_BITS-1:0] trig_level = LEVEL_RST;
  logic [TIMER_BITS-1:0]      hold_ticks = HOLDOFF_RST;
  logic [WIN_BITS-1:0]        win_len = WINDOW_RST;

  result_word_t awaited_words[$];
  int field_errors = 0;
  int sweeps_left = 5;       // channel sweeps the random traffic may still cause
  int unsigned cycle_count = 0;

  initial forever #5 clk = ~clk;

  // Drop one channel's window, position and timer; the last sample is kept.
  function automatic void wipe_channel(int c);
    foreach (cap_mem[c][i]) cap_mem[c][i] = '0;
    wpos[c] = '0;
    ticks[c] = '0;
  endfunction

  // Apply one accepted word to the predicted state and return the result word.
  function automatic result_word_t advance_recorder(req_word_t it);
    result_word_t r;
    int c;
    int unsigned span;
    r = '0;
    c = it.ch;
    if (it.req == REQ_CLEAR) begin
      for (int k = 0; k < NUM_CH; k++) wipe_channel(k);
    end else if ((it.req == REQ_SAMPLE || it.req == REQ_READ) && c < NUM_CH) begin
      if (it.req == REQ_READ) begin
        // A 16-bit index never reaches past DEPTH here.
        r.read_data = cap_mem[c][it.ridx];
      end else if (it.conn) begin
        if (ticks[c] != TIMER_MAX) ticks[c] = ticks[c] + 1'b1;
        if (retrig_en && it.smp > trig_level && last_smp[c] <= trig_level &&
            ticks[c] >= hold_ticks) begin
          // Restart capture: nothing is stored on the triggering sample.
          wpos[c] = '0;
          ticks[c] = '0;
          r.trig = 1'b1;
        end else begin
          span = (win_len == 0) ? 1 : (win_len > CAP_DEPTH) ? CAP_DEPTH : win_len;
          cap_mem[c][wpos[c]] = it.smp;
          // A position left past a shrunken window also wraps to 0 here.
          wpos[c] = (int'(wpos[c]) + 1 >= span) ? '0 : wpos[c] + 1'b1;
        end
        last_smp[c] = it.smp;
        r.through = it.smp;
      end else if (last_smp[c] != 0) begin
        // Source just went away on a live channel: drop its capture.
        wipe_channel(c);
        last_smp[c] = '0;
      end
      r.wpos = wpos[c];
    end
    return r;
  endfunction

  // Send one word; idle before it at the given percentage per cycle. Leave
  // start high on return so a back-to-back word needs no second assignment.
  task automatic send_word(input req_word_t it, input int idle_pct);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= it.req;
    in_channel <= it.ch;
    in_connected <= it.conn;
    in_sample <= it.smp;
    in_read_index <= it.ridx;
    do @(posedge clk); while (busy !== 1'b0);
    awaited_words.insert(awaited_words.size(), advance_recorder(it));
  endtask

  // Hold the sender until every awaited result word is in, then wait the tail.
  task automatic drain_results(input int tail);
    start <= 1'b0;
    do @(posedge clk); while (awaited_words.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  // Write all four registers while the block is idle, then track them.
  task automatic configure(input logic en, input logic signed [LEVEL_BITS-1:0] lvl,
                           input logic [TIMER_BITS-1:0] hold,
                           input logic [WIN_BITS-1:0] win);
    drain_results(4);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RETRIG;
    cfg_wdata <= {19'd0, en};
    @(posedge clk);
    cfg_index <= CFG_LEVEL;
    cfg_wdata <= {4'd0, lvl};
    @(posedge clk);
    cfg_index <= CFG_HOLDOFF;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_index <= CFG_WINDOW;
    cfg_wdata <= {3'd0, win};
    @(posedge clk);
    cfg_we <= 1'b0;
    retrig_en = en;
    trig_level = lvl;
    hold_ticks = hold;
    win_len = win;
  endtask

  function automatic req_word_t req_item(logic [REQ_BITS-1:0] req, int ch, logic conn,
                                         int smp, int ridx);
    req_word_t it;
    it.req = req;
    it.ch = CH_BITS'(ch);
    it.conn = conn;
    it.smp = SMP_BITS'(smp);
    it.ridx = IDX_BITS'(ridx);
    return it;
  endfunction

  // Reads of a fresh window, ignored words, and plain stores under reset config.
  task automatic test_reset_state_and_ignored();
    send_word(req_item(REQ_READ, 0, 1'b0, 0, 0), 0);
    send_word(req_item(REQ_READ, 5, 1'b1, -1, 65535), 0);
    send_word(req_item(REQ_SAMPLE, 6, 1'b1, 1234, 0), 0);
    send_word(req_item(REQ_READ, 7, 1'b0, 0, 3), 0);
    send_word(req_item(REQ_UNUSED, 0, 1'b1, 77, 9), 0);
    send_word(req_item(REQ_SAMPLE, 1, 1'b0, 555, 0), 0);
    send_word(req_item(REQ_SAMPLE, 0, 1'b1, 32767, 0), 0);
    send_word(req_item(REQ_SAMPLE, 0, 1'b1, -32768, 0), 0);
    send_word(req_item(REQ_READ, 0, 1'b0, 0, 1), 0);
  endtask

  // A disconnect on a live channel wipes it; clear-all acts even off-range.
  task automatic test_channel_clears();
    send_word(req_item(REQ_SAMPLE, 5, 1'b1, -1, 0), 0);
    send_word(req_item(REQ_SAMPLE, 5, 1'b0, 0, 0), 0);
    send_word(req_item(REQ_READ, 5, 1'b0, 0, 0), 0);
    send_word(req_item(REQ_CLEAR, 7, 1'b1, 100, 200), 0);
    send_word(req_item(REQ_READ, 0, 1'b0, 0, 0), 0);
  endtask

  // Rising edges past the level restart capture; with retrigger off they store.
  task automatic test_edge_retrigger();
    configure(1'b1, 16'sd0, 20'd0, 17'd4);
    send_word(req_item(REQ_SAMPLE, 2, 1'b1, -5, 0), 0);
    send_word(req_item(REQ_SAMPLE, 2, 1'b1, 10, 0), 0);
    send_word(req_item(REQ_SAMPLE, 2, 1'b1, 20, 0), 0);
    send_word(req_item(REQ_SAMPLE, 2, 1'b1, -1, 0), 0);
    send_word(req_item(REQ_SAMPLE, 2, 1'b1, 3, 0), 0);
    configure(1'b0, 16'sd0, 20'd0, 17'd4);
    send_word(req_item(REQ_SAMPLE, 2, 1'b1, -7, 0), 0);
    send_word(req_item(REQ_SAMPLE, 2, 1'b1, 9, 0), 0);
  endtask

  // Shrink the window under a channel whose position already lies past it.
  task automatic test_window_shrink();
    configure(1'b1, 16'sh7FFF, 20'd0, 17'd65536);
    send_word(req_item(REQ_SAMPLE, 3, 1'b1, 11, 0), 0);
    send_word(req_item(REQ_SAMPLE, 3, 1'b1, 22, 0), 0);
    send_word(req_item(REQ_SAMPLE, 3, 1'b1, 33, 0), 0);
    configure(1'b1, 16'sh7FFF, 20'd0, 17'd2);
    send_word(req_item(REQ_SAMPLE, 3, 1'b1, 44, 0), 0);
    send_word(req_item(REQ_READ, 3, 1'b0, 0, 3), 0);
  endtask

  // One random phase: mostly sample streams that cross the level back and
  // forth, with reads of the live window and some noise mixed in.
  task automatic run_phase(input logic en, input logic signed [LEVEL_BITS-1:0] lvl,
                           input logic [TIMER_BITS-1:0] hold,
                           input logic [WIN_BITS-1:0] win, input int count,
                           input int idle_pct);
    req_word_t it;
    int counted;
    int pick;
    int v;
    int unsigned span;
    configure(en, lvl, hold, win);
    span = (win == 0) ? 1 : (win > CAP_DEPTH) ? CAP_DEPTH : win;
    counted = 0;
    while (counted < count) begin
      it.req = REQ_SAMPLE;
      it.ch = CH_BITS'($urandom_range(NUM_CH - 1));
      it.conn = 1'b1;
      it.smp = SMP_BITS'($urandom);
      it.ridx = IDX_BITS'($urandom);
      pick = $urandom_range(999);
      if (pick < 20) begin
        it.req = ($urandom_range(1) != 0) ? REQ_READ : REQ_SAMPLE;
        it.ch = CH_BITS'($urandom_range(7, NUM_CH));
      end else if (pick < 35) begin
        it.req = REQ_UNUSED;
        it.ch = CH_BITS'($urandom);
      end else if (pick < 45 && sweeps_left > 0) begin
        it.req = REQ_CLEAR;
        it.ch = CH_BITS'($urandom);
        sweeps_left--;
      end else if (pick < 250) begin
        it.req = REQ_READ;
        // Mostly read where the window has been written.
        if ($urandom_range(3) != 0) it.ridx = IDX_BITS'($urandom_range(span > 64 ? 63 : span - 1));
      end else if (pick < 300) begin
        it.conn = 1'b0;
        // A disconnect on a live channel costs a full sweep: ration them.
        if (last_smp[it.ch] != 0) begin
          if (sweeps_left > 0 && $urandom_range(3) == 0) sweeps_left--;
          else it.conn = 1'b1;
        end
      end
      if (it.req == REQ_SAMPLE && it.conn) begin
        case ($urandom_range(6))
          0, 1: v = int'(lvl) - int'($urandom_range(50));
          2, 3: v = int'(lvl) + 1 + int'($urandom_range(50));
          4: v = 0;
          5: v = ($urandom_range(1) != 0) ? 32767 : -32768;
          default: v = int'(it.smp);
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        it.smp = SMP_BITS'(v);
      end
      // Now and then hold the sender until everything in flight is back.
      if ($urandom_range(99) == 0) drain_results(0);
      send_word(it, idle_pct);
      if (!(it.req == REQ_UNUSED ||
            ((it.req == REQ_SAMPLE || it.req == REQ_READ) && it.ch >= NUM_CH)))
        counted++;
    end
  endtask

  task automatic test_random_traffic();
    run_phase(1'b1, 16'sd0, 20'd0, 17'd8, 115, 0);
    run_phase(1'b1, -16'sd32768, 20'd2, 17'd1, 115, 83);
    run_phase(1'b1, 16'sd32767, 20'd0, 17'd5, 115, 26);
    run_phase(1'b0, 16'sd100, 20'd0, 17'd3, 115, 0);
    run_phase(1'b1, 16'sd2048, 20'd3, 17'd0, 115, 83);
    run_phase(1'b1, -16'sd1000, 20'd1, 17'd131071, 115, 26);
    run_phase(1'b1, 16'sd500, 20'hFFFFF, 17'd16, 115, 0);
    run_phase(1'b1, 16'sd300, 20'd4, 17'd65536, 115, 26);
    run_phase(RETRIG_RST, LEVEL_RST, HOLDOFF_RST, WINDOW_RST, 115, 83);
  endtask

  // Compare each result word with the oldest awaited one, field by field.
  always @(posedge clk) begin : check_results
    result_word_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_words.size() == 0) begin
        field_errors++;
        $display("%0t: unexpected result word: expected none, got through %0d read %0d",
                 $time, out_through, out_read_data);
        $display("%0t:   pos %0d trig %0b", $time, out_write_position, out_triggered);
      end else begin
        want = awaited_words.pop_front();
        if (out_through !== want.through) begin
          field_errors++;
          $display("%0t: through: expected %0d, got %0d", $time, want.through, out_through);
        end
        if (out_read_data !== want.read_data) begin
          field_errors++;
          $display("%0t: read_data: expected %0d, got %0d", $time, want.read_data,
                   out_read_data);
        end
        if (out_write_position !== want.wpos) begin
          field_errors++;
          $display("%0t: write_position: expected %0d, got %0d", $time, want.wpos,
                   out_write_position);
        end
        if (out_triggered !== want.trig) begin
          field_errors++;
          $display("%0t: triggered: expected %0b, got %0b", $time, want.trig, out_triggered);
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    // Hold reset, then let the power-up sweep run; the handshake waits it out through busy.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_reset_state_and_ignored();
    test_channel_clears();
    test_edge_retrigger();
    test_window_shrink();
    test_random_traffic();
    drain_results(TAIL_CYCLES);
    if (field_errors == 0 && awaited_words.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
